// ===== rtl/core/rra_pkg.sv =====
`timescale 1ns / 1ps

package rra_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MIN_SIZE     = 16;
  localparam int FIELD_W      = 11;
  localparam int SUM_W        = FIELD_W + 1;
  localparam int HDR_W        = FIELD_W + 1;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int STEP_W       = 5;
  localparam int READY_BIT    = HDR_W - 1;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [HDR_W-1:0]   hdr_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [STEP_W-1:0]  step_t;

  typedef enum logic [1:0] {
    KIND_RESERVE   = 2'd0,
    KIND_FIN_WRITE = 2'd1,
    KIND_TRY_READ  = 2'd2,
    KIND_FIN_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_GRANT  = 2'd0,
    STATUS_REFUSE = 2'd1,
    STATUS_BAD    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MEM_NONE     = 3'd0,
    MEM_RD_RPOS  = 3'd1,
    MEM_RD_HP    = 3'd2,
    MEM_WR_SKIP  = 3'd3,
    MEM_WR_LEN   = 3'd4,
    MEM_WR_READY = 3'd5
  } mem_op_t;

  typedef enum logic [3:0] {
    COND_NEVER       = 4'd0,
    COND_NOSPACE     = 4'd1,
    COND_FITS        = 4'd2,
    COND_BAD_FW      = 4'd3,
    COND_EMPTY       = 4'd4,
    COND_NOT_READY   = 4'd5,
    COND_HDR_ZERO    = 4'd6,
    COND_HDR_NONZERO = 4'd7,
    COND_BAD_FR_POS  = 4'd8,
    COND_BAD_FR_HDR  = 4'd9
  } cond_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_WRAP_W  = 3'd1,
    ACT_GRANT_W = 3'd2,
    ACT_ECHO    = 3'd3,
    ACT_SKIP_R  = 3'd4,
    ACT_GRANT_R = 3'd5,
    ACT_FREE_R  = 3'd6,
    ACT_FAIL    = 3'd7
  } act_t;

  typedef struct packed {
    logic    fetch;
    mem_op_t mem;
    cond_t   cond;
    step_t   target;
    act_t    act;
    logic    done;
  } ctrl_t;

  typedef struct packed {
    logic nospace;
    logic fits;
    logic bad_fw;
    logic empty;
    logic hdr_ready;
    logic hdr_zero;
    logic bad_fr_pos;
  } flags_t;

  localparam step_t ST_IDLE      = 5'd0;
  localparam step_t ST_RSV_CHK   = 5'd1;
  localparam step_t ST_RSV_FIT   = 5'd2;
  localparam step_t ST_RSV_WRAP  = 5'd3;
  localparam step_t ST_RSV_CHK2  = 5'd4;
  localparam step_t ST_RSV_GRANT = 5'd5;
  localparam step_t ST_FW_CHK    = 5'd6;
  localparam step_t ST_FW_MARK   = 5'd7;
  localparam step_t ST_TR_RD0    = 5'd8;
  localparam step_t ST_TR_EV0    = 5'd9;
  localparam step_t ST_TR_Z0     = 5'd10;
  localparam step_t ST_TR_SKIP   = 5'd11;
  localparam step_t ST_TR_RD1    = 5'd12;
  localparam step_t ST_TR_EV1    = 5'd13;
  localparam step_t ST_TR_Z1     = 5'd14;
  localparam step_t ST_TR_GRANT  = 5'd15;
  localparam step_t ST_FR_RD     = 5'd16;
  localparam step_t ST_FR_CHK    = 5'd17;
  localparam step_t ST_FR_FREE   = 5'd18;
  localparam step_t ST_END       = 5'd19;
  localparam step_t ST_FAIL      = 5'd20;

  function automatic ctrl_t mk_word(input logic fetch, input mem_op_t mem, input cond_t cond,
                                    input step_t target, input act_t act, input logic done);
    ctrl_t w;
    w.fetch  = fetch;
    w.mem    = mem;
    w.cond   = cond;
    w.target = target;
    w.act    = act;
    w.done   = done;
    return w;
  endfunction

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t w;
    unique case (pc)
      ST_IDLE:      w = mk_word(1'b1, MEM_NONE, COND_NEVER, ST_IDLE, ACT_NONE, 1'b0);
      ST_RSV_CHK:   w = mk_word(1'b0, MEM_NONE, COND_NOSPACE, ST_END, ACT_NONE, 1'b0);
      ST_RSV_FIT:   w = mk_word(1'b0, MEM_NONE, COND_FITS, ST_RSV_CHK2, ACT_NONE, 1'b0);
      ST_RSV_WRAP:  w = mk_word(1'b0, MEM_WR_SKIP, COND_NEVER, ST_IDLE, ACT_WRAP_W, 1'b0);
      ST_RSV_CHK2:  w = mk_word(1'b0, MEM_NONE, COND_NOSPACE, ST_END, ACT_NONE, 1'b0);
      ST_RSV_GRANT: w = mk_word(1'b0, MEM_WR_LEN, COND_NEVER, ST_IDLE, ACT_GRANT_W, 1'b1);
      ST_FW_CHK:    w = mk_word(1'b0, MEM_RD_HP, COND_BAD_FW, ST_FAIL, ACT_NONE, 1'b0);
      ST_FW_MARK:   w = mk_word(1'b0, MEM_WR_READY, COND_NEVER, ST_IDLE, ACT_ECHO, 1'b1);
      ST_TR_RD0:    w = mk_word(1'b0, MEM_RD_RPOS, COND_EMPTY, ST_END, ACT_NONE, 1'b0);
      ST_TR_EV0:    w = mk_word(1'b0, MEM_NONE, COND_NOT_READY, ST_END, ACT_NONE, 1'b0);
      ST_TR_Z0:     w = mk_word(1'b0, MEM_NONE, COND_HDR_NONZERO, ST_TR_GRANT, ACT_NONE, 1'b0);
      ST_TR_SKIP:   w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_SKIP_R, 1'b0);
      ST_TR_RD1:    w = mk_word(1'b0, MEM_RD_RPOS, COND_EMPTY, ST_END, ACT_NONE, 1'b0);
      ST_TR_EV1:    w = mk_word(1'b0, MEM_NONE, COND_NOT_READY, ST_END, ACT_NONE, 1'b0);
      ST_TR_Z1:     w = mk_word(1'b0, MEM_NONE, COND_HDR_ZERO, ST_END, ACT_NONE, 1'b0);
      ST_TR_GRANT:  w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_GRANT_R, 1'b1);
      ST_FR_RD:     w = mk_word(1'b0, MEM_RD_RPOS, COND_BAD_FR_POS, ST_FAIL, ACT_NONE, 1'b0);
      ST_FR_CHK:    w = mk_word(1'b0, MEM_NONE, COND_BAD_FR_HDR, ST_FAIL, ACT_NONE, 1'b0);
      ST_FR_FREE:   w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_FREE_R, 1'b1);
      ST_END:       w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_NONE, 1'b1);
      ST_FAIL:      w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_FAIL, 1'b1);
      default:      w = mk_word(1'b0, MEM_NONE, COND_NEVER, ST_IDLE, ACT_NONE, 1'b1);
    endcase
    return w;
  endfunction

  function automatic step_t entry_step(input kind_t kind);
    step_t s;
    unique case (kind)
      KIND_RESERVE:   s = ST_RSV_CHK;
      KIND_FIN_WRITE: s = ST_FW_CHK;
      KIND_TRY_READ:  s = ST_TR_RD0;
      KIND_FIN_READ:  s = ST_FR_RD;
      default:        s = ST_IDLE;
    endcase
    return s;
  endfunction

  function automatic field_t clamp_size(input field_t v);
    field_t s;
    s = v;
    if (v < field_t'(MIN_SIZE)) begin
      s = field_t'(MIN_SIZE);
    end else if (v > field_t'(BUFFER_BYTES)) begin
      s = field_t'(BUFFER_BYTES);
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/rra_req_if.sv =====
`timescale 1ns / 1ps

interface rra_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [rra_pkg::FIELD_W-1:0] length;
  logic [rra_pkg::FIELD_W-1:0] payload_offset;

  modport source (output valid, kind, length, payload_offset, input ready);
  modport sink   (input valid, kind, length, payload_offset, output ready);
endinterface

// ===== rtl/core/rra_rsp_if.sv =====
`timescale 1ns / 1ps

interface rra_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [rra_pkg::FIELD_W-1:0] result_offset;
  logic [rra_pkg::FIELD_W-1:0] result_length;

  modport source (output valid, status, result_offset, result_length, input ready);
  modport sink   (input valid, status, result_offset, result_length, output ready);
endinterface

// ===== rtl/core/rra_ram.sv =====
`timescale 1ns / 1ps

module rra_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rra_useq.sv =====
`timescale 1ns / 1ps

module rra_useq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  rra_pkg::kind_t     kind,
  input  rra_pkg::flags_t    flags,
  input  logic               stall,
  output rra_pkg::ctrl_t     ctrl
);

  rra_pkg::step_t pc;
  rra_pkg::step_t pc_next;
  logic           taken;

  assign ctrl = rra_pkg::ucode(pc);

  always_comb begin
    unique case (ctrl.cond)
      rra_pkg::COND_NEVER:       taken = 1'b0;
      rra_pkg::COND_NOSPACE:     taken = flags.nospace;
      rra_pkg::COND_FITS:        taken = flags.fits;
      rra_pkg::COND_BAD_FW:      taken = flags.bad_fw;
      rra_pkg::COND_EMPTY:       taken = flags.empty;
      rra_pkg::COND_NOT_READY:   taken = !flags.hdr_ready;
      rra_pkg::COND_HDR_ZERO:    taken = flags.hdr_zero;
      rra_pkg::COND_HDR_NONZERO: taken = !flags.hdr_zero;
      rra_pkg::COND_BAD_FR_POS:  taken = flags.bad_fr_pos;
      rra_pkg::COND_BAD_FR_HDR:  taken = !flags.hdr_ready || flags.hdr_zero;
      default:                   taken = 1'b0;
    endcase
  end

  always_comb begin
    priority if (ctrl.fetch) begin
      pc_next = in_fire ? rra_pkg::entry_step(kind) : pc;
    end else if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else if (ctrl.done) begin
      pc_next = rra_pkg::ST_IDLE;
    end else begin
      pc_next = rra_pkg::step_t'(pc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rra_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/core/rra_dpath.sv =====
`timescale 1ns / 1ps

module rra_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  rra_pkg::ctrl_t       ctrl,
  input  logic                 in_fire,
  input  rra_pkg::field_t      in_length,
  input  rra_pkg::field_t      in_offset,
  input  logic                 cfg_wr_en,
  input  rra_pkg::field_t      cfg_wr_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output rra_pkg::field_t      out_offset,
  output rra_pkg::field_t      out_length,
  output rra_pkg::flags_t      flags,
  output logic                 stall
);

  rra_pkg::field_t  size;
  rra_pkg::field_t  wpos;
  rra_pkg::field_t  rpos;
  rra_pkg::field_t  length;
  rra_pkg::field_t  offset;
  rra_pkg::status_t status;
  rra_pkg::field_t  res_off;
  rra_pkg::field_t  res_len;

  rra_pkg::field_t  wpos_next;
  rra_pkg::field_t  rpos_next;
  rra_pkg::status_t status_next;
  rra_pkg::field_t  res_off_next;
  rra_pkg::field_t  res_len_next;

  rra_pkg::field_t  free_bytes;
  rra_pkg::sum_t    total;
  rra_pkg::sum_t    w_end;
  rra_pkg::sum_t    r_end;
  rra_pkg::field_t  hp;
  rra_pkg::hdr_t    rd_data;
  rra_pkg::field_t  hdr_len;
  logic             go;

  logic             mem_wr;
  logic             mem_rd;
  rra_pkg::addr_t   wr_addr;
  rra_pkg::addr_t   rd_addr;
  rra_pkg::hdr_t    wr_data;

  assign stall = ctrl.done && out_valid && !out_ready;
  assign go    = !stall;

  assign hdr_len    = rd_data[rra_pkg::FIELD_W-1:0];
  assign free_bytes = (wpos >= rpos) ? rra_pkg::field_t'(size - wpos + rpos)
                                     : rra_pkg::field_t'(rpos - wpos);
  assign total      = rra_pkg::sum_t'(2 * rra_pkg::HEADER_BYTES) + {1'b0, length};
  assign w_end      = {1'b0, wpos} + total;
  assign r_end      = {1'b0, rpos} + rra_pkg::sum_t'(2 * rra_pkg::HEADER_BYTES)
                      + {1'b0, hdr_len};
  assign hp         = offset - rra_pkg::field_t'(rra_pkg::HEADER_BYTES);

  always_comb begin
    flags.nospace    = (length == '0) || ({1'b0, free_bytes} <= total);
    flags.fits       = w_end <= {1'b0, size};
    flags.bad_fw     = (offset < rra_pkg::field_t'(rra_pkg::HEADER_BYTES)) || (hp >= size);
    flags.empty      = rpos == wpos;
    flags.hdr_ready  = rd_data[rra_pkg::READY_BIT];
    flags.hdr_zero   = hdr_len == '0;
    flags.bad_fr_pos = (rpos == wpos) ||
                       ({1'b0, offset} !=
                        {1'b0, rpos} + rra_pkg::sum_t'(rra_pkg::HEADER_BYTES));
  end

  // Header RAM port selection
  always_comb begin
    mem_wr  = 1'b0;
    mem_rd  = 1'b0;
    wr_addr = wpos[rra_pkg::ADDR_W-1:0];
    rd_addr = rpos[rra_pkg::ADDR_W-1:0];
    wr_data = {1'b1, rra_pkg::field_t'(0)};
    unique case (ctrl.mem)
      rra_pkg::MEM_NONE: begin
      end
      rra_pkg::MEM_RD_RPOS: begin
        mem_rd = 1'b1;
      end
      rra_pkg::MEM_RD_HP: begin
        mem_rd  = 1'b1;
        rd_addr = hp[rra_pkg::ADDR_W-1:0];
      end
      rra_pkg::MEM_WR_SKIP: begin
        mem_wr = go;
      end
      rra_pkg::MEM_WR_LEN: begin
        mem_wr  = go;
        wr_data = {1'b0, length};
      end
      rra_pkg::MEM_WR_READY: begin
        mem_wr  = go;
        wr_addr = hp[rra_pkg::ADDR_W-1:0];
        wr_data = {1'b1, hdr_len};
      end
      default: begin
      end
    endcase
  end

  rra_ram #(
    .WIDTH (rra_pkg::HDR_W),
    .DEPTH (rra_pkg::BUFFER_BYTES)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mem_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    wpos_next    = wpos;
    rpos_next    = rpos;
    status_next  = status;
    res_off_next = res_off;
    res_len_next = res_len;
    unique case (ctrl.act)
      rra_pkg::ACT_NONE: begin
      end
      rra_pkg::ACT_WRAP_W: begin
        wpos_next = '0;
      end
      rra_pkg::ACT_GRANT_W: begin
        status_next  = rra_pkg::STATUS_GRANT;
        res_off_next = wpos + rra_pkg::field_t'(rra_pkg::HEADER_BYTES);
        wpos_next    = (w_end >= {1'b0, size}) ? '0 : w_end[rra_pkg::FIELD_W-1:0];
      end
      rra_pkg::ACT_ECHO: begin
        status_next  = rra_pkg::STATUS_GRANT;
        res_off_next = offset;
      end
      rra_pkg::ACT_SKIP_R: begin
        rpos_next = '0;
      end
      rra_pkg::ACT_GRANT_R: begin
        status_next  = rra_pkg::STATUS_GRANT;
        res_off_next = rpos + rra_pkg::field_t'(rra_pkg::HEADER_BYTES);
        res_len_next = hdr_len;
      end
      rra_pkg::ACT_FREE_R: begin
        status_next  = rra_pkg::STATUS_GRANT;
        res_off_next = offset;
        rpos_next    = (r_end >= {1'b0, size}) ? '0 : r_end[rra_pkg::FIELD_W-1:0];
      end
      rra_pkg::ACT_FAIL: begin
        status_next = rra_pkg::STATUS_BAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= rra_pkg::field_t'(rra_pkg::BUFFER_BYTES);
      wpos <= '0;
      rpos <= '0;
    end else if (cfg_wr_en) begin
      // new size empties the ring
      size <= rra_pkg::clamp_size(cfg_wr_data);
      wpos <= '0;
      rpos <= '0;
    end else if (go) begin
      wpos <= wpos_next;
      rpos <= rpos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      length  <= in_length;
      offset  <= in_offset;
      status  <= rra_pkg::STATUS_REFUSE;
      res_off <= '0;
      res_len <= '0;
    end else if (go) begin
      status  <= status_next;
      res_off <= res_off_next;
      res_len <= res_len_next;
    end
  end

  // Output register: load on the last step, hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.done && go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done && go) begin
      out_status <= status_next;
      out_offset <= res_off_next;
      out_length <= res_len_next;
    end
  end

endmodule

// ===== rtl/core/variable_record_ring_allocator_top.sv =====
`timescale 1ns / 1ps

// Ring allocator for variable-length records: reserve, finish-write, try-read and
// finish-read requests come in on req, one answer per request leaves on rsp. A small
// control store steps a plain datapath, one control word per cycle while no finished
// answer stalls on rsp, and every header lookup goes through the header RAM's
// registered read port. A reserve lays a skip marker and wraps the head when the
// record does not fit before the end, a finish-read can be refused early, and a
// try-read can pass a skip marker. One request is in work at a time; the next is
// taken while the last answer still waits on rsp. Writing buffer_size empties the ring.
module variable_record_ring_allocator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [10:0]           cfg_wr_data,
  rra_req_if.sink               req,
  rra_rsp_if.source             rsp
);

  rra_pkg::ctrl_t  ctrl;
  rra_pkg::flags_t flags;
  logic            stall;
  logic            in_fire;

  assign req.ready = ctrl.fetch;
  assign in_fire   = req.valid && ctrl.fetch;

  rra_useq u_useq (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .kind    (rra_pkg::kind_t'(req.kind)),
    .flags   (flags),
    .stall   (stall),
    .ctrl    (ctrl)
  );

  rra_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .in_fire     (in_fire),
    .in_length   (req.length),
    .in_offset   (req.payload_offset),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_offset  (rsp.result_offset),
    .out_length  (rsp.result_length),
    .flags       (flags),
    .stall       (stall)
  );

endmodule
